// ===== sv/tpi_pkg.sv =====
// types and constants for the two-wire programming link frame master
// no dependencies; imported by tpi_link_frame_master
package tpi_pkg;

  // sequence kind; the command selector uses the same codes
  typedef enum logic [1:0] {
    MODE_IDLE   = 2'd0,
    MODE_ENABLE = 2'd1,
    MODE_WRITE  = 2'd2,
    MODE_READ   = 2'd3
  } mode_t;

  // configuration register indexes
  localparam logic [1:0] CFG_SEARCH_LIMIT  = 2'd0;
  localparam logic [1:0] CFG_ENABLE_CLOCKS = 2'd1;

  // configuration reset values
  localparam logic [7:0] SEARCH_LIMIT_RST  = 8'd131;
  localparam logic [7:0] ENABLE_CLOCKS_RST = 8'd16;

  // frame layout: start, eight data, parity, two stops
  localparam int unsigned FRAME_BITS = 12;
  localparam logic [3:0] POS_DATA_LAST = 4'd8;
  localparam logic [3:0] POS_PARITY    = 4'd9;
  localparam logic [3:0] POS_STOP1     = 4'd10;
  localparam logic [3:0] POS_FRAME_END = 4'(FRAME_BITS - 1);

  // receive error flag bits
  localparam int unsigned ERR_PARITY = 0;
  localparam int unsigned ERR_STOP1  = 1;
  localparam int unsigned ERR_STOP2  = 2;

endpackage

// ===== sv/tpi_link_frame_master.sv =====
// bit-level master for a two-wire programming link, one request per link period
// depends on tpi_pkg for the sequence enum and frame constants
// the result of each accepted request is held in the output register
// throughput: one request per cycle while the input is not stalled; the only loop is the sequence state update
// stall on the input follows the output register (full and stalled)
// reset: synchronous, idle with the target reset pin high, registers at defaults
module tpi_link_frame_master
  import tpi_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  // configuration write port
  input  logic       cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_data,
  // input channel
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] func,
  input  logic [7:0] tx_byte,
  input  logic       rx_bit,
  // output channel
  output logic       out_valid,
  input  logic       out_stall,
  output logic       data_out,
  output logic       data_drive,
  output logic       reset_level,
  output logic       busy_res,
  output logic       done_res,
  output logic [7:0] rx_byte,
  output logic       parity_error,
  output logic       stop1_error,
  output logic       stop2_error,
  output logic       timeout
);

  // configuration registers
  logic [7:0] search_limit;
  logic [7:0] enable_clocks;

  // sequence state
  mode_t      mode, mode_next;
  logic [3:0] bit_position, bit_position_next;
  logic [7:0] shift_byte, shift_byte_next;
  logic       parity_acc, parity_acc_next;
  logic [7:0] period_count, period_count_next;
  logic       searching, searching_next;
  logic [2:0] error_flags, error_flags_next;
  logic       reset_pin, reset_pin_next;

  // request working values
  logic       accept;
  logic       idle_tick;
  logic       first;
  mode_t      act;
  logic [3:0] pos_cur;
  logic [3:0] rd_pos;
  logic [7:0] shift_cur;
  logic       parity_cur;
  logic [7:0] count_cur;
  logic       search_cur;
  logic [2:0] err_cur;
  logic [7:0] enable_lim;
  logic [7:0] search_lim;
  logic [7:0] count_inc;
  logic       done;
  logic       tmo;

  // result values before the output register
  logic       data_out_next;
  logic       data_drive_next;
  logic       reset_level_next;
  logic       busy_next;
  logic [7:0] rx_byte_next;
  logic [2:0] flags_next;

  assign in_stall = out_valid & out_stall;
  assign accept   = in_valid & ~in_stall;

  // configuration writes, indexes past the list are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      search_limit  <= SEARCH_LIMIT_RST;
      enable_clocks <= ENABLE_CLOCKS_RST;
    end else if (cfg_we) begin
      if (cfg_index == CFG_SEARCH_LIMIT) begin
        search_limit <= cfg_data;
      end else if (cfg_index == CFG_ENABLE_CLOCKS) begin
        enable_clocks <= cfg_data;
      end
    end
  end

  // starting values: fresh on a new command, else the stored state
  always_comb begin
    first      = (mode == MODE_IDLE);
    idle_tick  = first && (mode_t'(func) == MODE_IDLE);
    act        = first ? mode_t'(func) : mode;
    pos_cur    = first ? 4'd0 : bit_position;
    count_cur  = first ? 8'd0 : period_count;
    search_cur = first ? (mode_t'(func) == MODE_READ) : searching;
    err_cur    = first ? 3'd0 : error_flags;
    parity_cur = first ? 1'b0 : parity_acc;
    if (first) begin
      shift_cur = (mode_t'(func) == MODE_WRITE) ? tx_byte : 8'd0;
    end else begin
      shift_cur = shift_byte;
    end
    enable_lim = (enable_clocks == 8'd0) ? 8'd1 : enable_clocks;
    search_lim = (search_limit == 8'd0) ? 8'd1 : search_limit;
    count_inc  = count_cur + 8'd1;
    rd_pos     = pos_cur + 4'd1;
  end

  // next state of the sequence
  always_comb begin
    bit_position_next = pos_cur;
    shift_byte_next   = shift_cur;
    parity_acc_next   = parity_cur;
    period_count_next = count_cur;
    searching_next    = search_cur;
    error_flags_next  = err_cur;
    reset_pin_next    = reset_pin;
    done              = 1'b0;
    tmo               = 1'b0;
    unique case (act)
      MODE_IDLE: begin
        // idle tick, nothing moves
      end
      MODE_ENABLE: begin
        if (first) begin
          reset_pin_next = 1'b1;
        end else begin
          reset_pin_next    = 1'b0;
          period_count_next = count_inc;
          done              = (count_inc >= enable_lim);
        end
      end
      MODE_WRITE: begin
        if (pos_cur != 4'd0 && pos_cur <= POS_DATA_LAST) begin
          parity_acc_next = parity_cur ^ shift_cur[0];
          shift_byte_next = shift_cur >> 1;
        end
        if (pos_cur >= POS_FRAME_END) begin
          done = 1'b1;
        end else begin
          bit_position_next = pos_cur + 4'd1;
        end
      end
      MODE_READ: begin
        if (search_cur) begin
          if (!rx_bit) begin
            searching_next    = 1'b0;
            bit_position_next = 4'd0;
          end else begin
            period_count_next = count_inc;
            if (count_inc >= search_lim) begin
              done = 1'b1;
              tmo  = 1'b1;
            end
          end
        end else begin
          bit_position_next = rd_pos;
          if (rd_pos != 4'd0 && rd_pos <= POS_DATA_LAST) begin
            shift_byte_next = {rx_bit, shift_cur[7:1]};
            parity_acc_next = parity_cur ^ rx_bit;
          end else if (rd_pos == POS_PARITY) begin
            error_flags_next[ERR_PARITY] = err_cur[ERR_PARITY] | (rx_bit != parity_cur);
          end else if (rd_pos == POS_STOP1) begin
            error_flags_next[ERR_STOP1] = err_cur[ERR_STOP1] | ~rx_bit;
          end else begin
            error_flags_next[ERR_STOP2] = err_cur[ERR_STOP2] | ~rx_bit;
            done                        = 1'b1;
          end
        end
      end
      default: begin
      end
    endcase
    if (idle_tick || done) begin
      mode_next = MODE_IDLE;
    end else begin
      mode_next = act;
    end
  end

  // result fields for this period
  always_comb begin
    data_out_next    = 1'b0;
    data_drive_next  = 1'b1;
    reset_level_next = reset_pin_next;
    busy_next        = ~done;
    rx_byte_next     = 8'd0;
    flags_next       = 3'd0;
    unique case (act)
      MODE_IDLE: begin
        data_out_next = 1'b1;
        busy_next     = 1'b0;
      end
      MODE_ENABLE: begin
        data_out_next = ~first;
      end
      MODE_WRITE: begin
        if (pos_cur == 4'd0) begin
          data_out_next = 1'b0;
        end else if (pos_cur <= POS_DATA_LAST) begin
          data_out_next = shift_cur[0];
        end else if (pos_cur == POS_PARITY) begin
          data_out_next = parity_cur;
        end else begin
          data_out_next = 1'b1;
        end
      end
      MODE_READ: begin
        data_drive_next = 1'b0;
        if (done && !tmo) begin
          rx_byte_next = shift_byte_next;
          flags_next   = error_flags_next;
        end
      end
      default: begin
      end
    endcase
  end

  // sequence state registers, updated on each accepted request
  always_ff @(posedge clk) begin
    if (rst) begin
      mode         <= MODE_IDLE;
      bit_position <= 4'd0;
      shift_byte   <= 8'd0;
      parity_acc   <= 1'b0;
      period_count <= 8'd0;
      searching    <= 1'b0;
      error_flags  <= 3'd0;
      reset_pin    <= 1'b1;
    end else if (accept) begin
      mode         <= mode_next;
      bit_position <= bit_position_next;
      shift_byte   <= shift_byte_next;
      parity_acc   <= parity_acc_next;
      period_count <= period_count_next;
      searching    <= searching_next;
      error_flags  <= error_flags_next;
      reset_pin    <= reset_pin_next;
    end
  end

  // output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // output payload register
  always_ff @(posedge clk) begin
    if (accept) begin
      data_out     <= data_out_next;
      data_drive   <= data_drive_next;
      reset_level  <= reset_level_next;
      busy_res     <= busy_next;
      done_res     <= done;
      rx_byte      <= rx_byte_next;
      parity_error <= flags_next[ERR_PARITY];
      stop1_error  <= flags_next[ERR_STOP1];
      stop2_error  <= flags_next[ERR_STOP2];
      timeout      <= tmo;
    end
  end

endmodule

// ===== tb/tpi_link_frame_master_test.sv =====
// self-checking testbench for the two-wire programming link frame master
// depends on tpi_pkg and tpi_link_frame_master; random gaps on both channels,
// a cycle-level predictor of the pin levels and status checks every result
module tpi_link_frame_master_test;
  import tpi_pkg::*;

  // spare register indexes, writes there must be ignored
  localparam logic [1:0] CFG_SPARE_2 = 2'd2;
  localparam logic [1:0] CFG_SPARE_3 = 2'd3;

  typedef struct packed {
    mode_t      func;
    logic [7:0] tx;
    logic       rx;
  } req_t;

  typedef struct packed {
    logic       data_out;
    logic       data_drive;
    logic       reset_level;
    logic       busy_res;
    logic       done_res;
    logic [7:0] rx_byte;
    logic       parity_error;
    logic       stop1_error;
    logic       stop2_error;
    logic       timeout;
  } period_t;

  logic       clk;
  logic       rst = 1'b1;
  logic       cfg_we = 1'b0;
  logic [1:0] cfg_index = '0;
  logic [7:0] cfg_data = '0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [1:0] func = '0;
  logic [7:0] tx_byte = '0;
  logic       rx_bit = 1'b0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic       data_out;
  logic       data_drive;
  logic       reset_level;
  logic       busy_res;
  logic       done_res;
  logic [7:0] rx_byte;
  logic       parity_error;
  logic       stop1_error;
  logic       stop2_error;
  logic       timeout;

  tpi_link_frame_master i_dut (.*);

  // pending requests and expected link periods
  req_t    pend_q[$];
  period_t want_q[$];

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // watchdog
  initial begin
    #2000000;
    $display("run timed out, %0d periods still expected", want_q.size());
    $display("TEST FAILED");
    $finish;
  end

  // predictor copy of registers and sequence state
  logic [7:0] lim_search = SEARCH_LIMIT_RST;
  logic [7:0] lim_enable = ENABLE_CLOCKS_RST;
  mode_t      st_mode = MODE_IDLE;
  logic [3:0] st_pos = '0;
  logic [7:0] st_shift = '0;
  logic       st_par = 1'b0;
  logic [7:0] st_cnt = '0;
  logic       st_search = 1'b0;
  logic [2:0] st_err = '0;
  logic       st_rst_pin = 1'b1;

  int unsigned n_queued, n_req, n_results, n_mismatch;
  int unsigned n_enable, n_sent, n_recv, n_recv_bad, n_timeout, n_settings;

  function automatic logic [7:0] at_least_one(logic [7:0] v);
    return (v == 8'd0) ? 8'd1 : v;
  endfunction

  // pin levels and status of one link period
  function automatic period_t next_period(req_t r);
    period_t p;
    logic    first;
    logic    fin;
    p = '0;
    p.data_drive = 1'b1;
    first = 1'b0;
    fin = 1'b0;
    if (st_mode == MODE_IDLE) begin
      if (r.func == MODE_IDLE) begin
        p.data_out = 1'b1;
        p.reset_level = st_rst_pin;
        return p;
      end
      st_mode = r.func;
      st_pos = '0;
      st_cnt = '0;
      st_search = (r.func == MODE_READ);
      st_err = '0;
      st_par = 1'b0;
      st_shift = (r.func == MODE_WRITE) ? r.tx : 8'h00;
      first = 1'b1;
    end
    case (st_mode)
      MODE_ENABLE: begin
        if (first) begin
          st_rst_pin = 1'b1;
          p.data_out = 1'b0;
        end else begin
          st_rst_pin = 1'b0;
          p.data_out = 1'b1;
          st_cnt++;
          fin = (st_cnt >= at_least_one(lim_enable));
          if (fin) n_enable++;
        end
      end
      MODE_WRITE: begin
        if (st_pos == 4'd0) begin
          p.data_out = 1'b0;
        end else if (st_pos <= POS_DATA_LAST) begin
          p.data_out = st_shift[0];
          st_par ^= st_shift[0];
          st_shift >>= 1;
        end else if (st_pos == POS_PARITY) begin
          p.data_out = st_par;
        end else begin
          p.data_out = 1'b1;
        end
        if (st_pos >= POS_FRAME_END) begin
          fin = 1'b1;
          n_sent++;
        end else begin
          st_pos++;
        end
      end
      default: begin
        // read: line released, search then sample
        p.data_drive = 1'b0;
        p.data_out = 1'b0;
        if (st_search) begin
          if (!r.rx) begin
            st_search = 1'b0;
            st_pos = '0;
          end else begin
            st_cnt++;
            if (st_cnt >= at_least_one(lim_search)) begin
              fin = 1'b1;
              p.timeout = 1'b1;
              n_timeout++;
            end
          end
        end else begin
          st_pos++;
          if (st_pos <= POS_DATA_LAST) begin
            st_shift = {r.rx, st_shift[7:1]};
            st_par ^= r.rx;
          end else if (st_pos == POS_PARITY) begin
            st_err[ERR_PARITY] |= (r.rx != st_par);
          end else if (st_pos == POS_STOP1) begin
            st_err[ERR_STOP1] |= !r.rx;
          end else begin
            st_err[ERR_STOP2] |= !r.rx;
            fin = 1'b1;
            p.rx_byte = st_shift;
            p.parity_error = st_err[ERR_PARITY];
            p.stop1_error = st_err[ERR_STOP1];
            p.stop2_error = st_err[ERR_STOP2];
            n_recv++;
            if (st_err != 3'b000) n_recv_bad++;
          end
        end
      end
    endcase
    if (fin) st_mode = MODE_IDLE;
    p.reset_level = st_rst_pin;
    p.busy_res = !fin;
    p.done_res = fin;
    return p;
  endfunction

  // gap length: mostly none or short, a few long, now and then a calm stretch
  function automatic int unsigned pick_gap(inout int unsigned calm);
    int unsigned r;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 2) begin
      calm = $urandom_range(20, 120);
      return 0;
    end
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 9);
    return $urandom_range(10, 30);
  endfunction

  // request driver
  req_t        cur_req;
  int unsigned hold_left, drv_calm;

  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        want_q.push_back(next_period(cur_req));
        n_req++;
      end
      if (!in_valid || !in_stall) begin
        if (hold_left > 0 || pend_q.size() == 0) begin
          if (hold_left > 0) hold_left--;
          in_valid <= 1'b0;
        end else begin
          cur_req = pend_q.pop_front();
          func <= cur_req.func;
          tx_byte <= cur_req.tx;
          rx_bit <= cur_req.rx;
          in_valid <= 1'b1;
          hold_left = pick_gap(drv_calm);
        end
      end
    end
  end

  task automatic note_mismatch(string msg);
    n_mismatch++;
    if (n_mismatch <= 10) $display("%0t: %s", $time, msg);
  endtask

  task automatic check_field(string name, int unsigned got, int unsigned want);
    if (got != want)
      note_mismatch($sformatf("period %0d %s: expected %0h, got %0h",
                              n_results, name, want, got));
  endtask

  // result monitor with random stall
  int unsigned stall_left, mon_calm;

  always @(posedge clk) begin : monitor
    period_t got;
    period_t want;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        got = '{data_out: data_out, data_drive: data_drive, reset_level: reset_level,
                busy_res: busy_res, done_res: done_res, rx_byte: rx_byte,
                parity_error: parity_error, stop1_error: stop1_error,
                stop2_error: stop2_error, timeout: timeout};
        if (want_q.size() == 0) begin
          note_mismatch($sformatf("period %0d arrived with no request pending", n_results));
        end else begin
          want = want_q.pop_front();
          check_field("data_out", got.data_out, want.data_out);
          check_field("data_drive", got.data_drive, want.data_drive);
          check_field("reset_level", got.reset_level, want.reset_level);
          check_field("busy_res", got.busy_res, want.busy_res);
          check_field("done_res", got.done_res, want.done_res);
          check_field("rx_byte", got.rx_byte, want.rx_byte);
          check_field("parity_error", got.parity_error, want.parity_error);
          check_field("stop1_error", got.stop1_error, want.stop1_error);
          check_field("stop2_error", got.stop2_error, want.stop2_error);
          check_field("timeout", got.timeout, want.timeout);
        end
        n_results++;
      end
      if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else begin
        out_stall <= 1'b0;
        stall_left = pick_gap(mon_calm);
      end
    end
  end

  // stimulus helpers
  function automatic logic [7:0] rnd_byte();
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic logic rnd_bit();
    return 1'($urandom_range(0, 1));
  endfunction

  function automatic mode_t any_func();
    return mode_t'($urandom_range(0, 3));
  endfunction

  task automatic queue_req(mode_t f, logic [7:0] tx, logic rx);
    req_t r;
    r.func = f;
    r.tx = tx;
    r.rx = rx;
    pend_q.push_back(r);
    n_queued++;
  endtask

  // later periods of a sequence carry random commands, which must be ignored
  task automatic send_enable();
    queue_req(MODE_ENABLE, rnd_byte(), rnd_bit());
    repeat (at_least_one(lim_enable)) queue_req(any_func(), rnd_byte(), rnd_bit());
  endtask

  task automatic send_frame(logic [7:0] b);
    queue_req(MODE_WRITE, b, rnd_bit());
    repeat (FRAME_BITS - 1) queue_req(any_func(), rnd_byte(), rnd_bit());
  endtask

  // read with idle periods before the start bit; bad selects broken parity/stops
  task automatic recv_frame(int unsigned idle, logic [7:0] b, logic [2:0] bad);
    int unsigned n;
    n = at_least_one(lim_search);
    if (idle >= n) begin
      // no start bit before the search runs out
      queue_req(MODE_READ, rnd_byte(), 1'b1);
      repeat (n - 1) queue_req(any_func(), rnd_byte(), 1'b1);
      return;
    end
    queue_req(MODE_READ, rnd_byte(), (idle == 0) ? 1'b0 : 1'b1);
    if (idle > 0) begin
      repeat (idle - 1) queue_req(any_func(), rnd_byte(), 1'b1);
      queue_req(any_func(), rnd_byte(), 1'b0);
    end
    for (int i = 0; i < 8; i++) queue_req(any_func(), rnd_byte(), b[i]);
    queue_req(any_func(), rnd_byte(), (^b) ^ bad[ERR_PARITY]);
    queue_req(any_func(), rnd_byte(), !bad[ERR_STOP1]);
    queue_req(any_func(), rnd_byte(), !bad[ERR_STOP2]);
  endtask

  task automatic drain();
    do @(posedge clk); while (pend_q.size() != 0 || in_valid || want_q.size() != 0);
  endtask

  // wait for all results, then pad with idle periods until no sequence runs
  task automatic settle();
    drain();
    while (st_mode != MODE_IDLE) begin
      repeat (8) queue_req(MODE_IDLE, rnd_byte(), rnd_bit());
      drain();
    end
  endtask

  task automatic write_reg(logic [1:0] idx, logic [7:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_SEARCH_LIMIT:  lim_search = val;
      CFG_ENABLE_CLOCKS: lim_enable = val;
      default: ;
    endcase
  endtask

  // random mix of mostly well-formed sequences, some noise
  task automatic run_mix(int unsigned budget);
    int unsigned stop_at, r, n, idle;
    stop_at = n_queued + budget;
    while (n_queued < stop_at) begin
      r = $urandom_range(0, 99);
      n = at_least_one(lim_search);
      if (r < 20) begin
        if (at_least_one(lim_enable) <= 20 || r < 2) send_enable();
        else send_frame(rnd_byte());
      end else if (r < 50) begin
        send_frame(rnd_byte());
      end else if (r < 85) begin
        idle = ($urandom_range(0, 9) == 0) ? n - 1 : $urandom_range(0, (n - 1 < 6) ? n - 1 : 6);
        recv_frame(idle, rnd_byte(), {$urandom_range(0, 5) == 0, $urandom_range(0, 5) == 0,
                                      $urandom_range(0, 5) == 0});
      end else if (r < 92) begin
        if (n <= 20 || r < 86) recv_frame(n, rnd_byte(), 3'b000);
        else recv_frame(0, rnd_byte(), 3'b000);
      end else if (r < 97) begin
        repeat ($urandom_range(1, 4)) queue_req(MODE_IDLE, rnd_byte(), rnd_bit());
      end else begin
        repeat ($urandom_range(1, 6)) queue_req(any_func(), rnd_byte(), rnd_bit());
        settle();
      end
    end
  endtask

  initial begin : stimulus
    logic [7:0]  set_search[6];
    logic [7:0]  set_enable[6];
    int unsigned k;
    set_search = '{8'd1, 8'd255, 8'd0, 8'd5, 8'd9, 8'd131};
    set_enable = '{8'd1, 8'd255, 8'd0, 8'd2, 8'd9, 8'd16};
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // directed: idle, byte extremes, clean and broken reads, enable at reset values
    queue_req(MODE_IDLE, 8'h00, 1'b0);
    queue_req(MODE_IDLE, 8'hFF, 1'b1);
    send_frame(8'h00);
    send_frame(8'hFF);
    send_frame(8'h96);
    recv_frame(0, 8'hA5, 3'b000);
    recv_frame(3, 8'h3C, 3'b111);
    send_enable();
    n_settings = 1;
    settle();
    run_mix(70);
    settle();

    // register settings, extremes and zero among them
    for (int ph = 0; ph < 6; ph++) begin
      repeat (3) @(posedge clk);
      if (ph == 4) begin
        set_search[ph] = 8'($urandom_range(2, 40));
        set_enable[ph] = 8'($urandom_range(2, 40));
      end
      write_reg(CFG_SEARCH_LIMIT, set_search[ph]);
      write_reg(CFG_ENABLE_CLOCKS, set_enable[ph]);
      if (ph == 3) begin
        write_reg(CFG_SPARE_2, rnd_byte());
        write_reg(CFG_SPARE_3, rnd_byte());
      end
      n_settings++;
      // search that runs out right at this limit
      recv_frame(at_least_one(lim_search), rnd_byte(), 3'b000);
      run_mix(70);
      settle();
    end

    // final drain with a bound, then look for stray results
    k = 0;
    while ((pend_q.size() != 0 || in_valid || want_q.size() != 0) && k < 20000) begin
      @(posedge clk);
      k++;
    end
    repeat (5) @(posedge clk);
    if (want_q.size() != 0)
      note_mismatch($sformatf("%0d expected periods never came", want_q.size()));

    $display("covered %0d requests and %0d results over %0d register settings",
             n_req, n_results, n_settings);
    $display("frames sent %0d, received %0d (%0d flagged), search timeouts %0d, enables %0d",
             n_sent, n_recv, n_recv_bad, n_timeout, n_enable);
    if (n_mismatch == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("%0d mismatches", n_mismatch);
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ===== files.f =====
sv/tpi_pkg.sv
sv/tpi_link_frame_master.sv
tb/tpi_link_frame_master_test.sv
